FILE: hdl/frms_pkg.sv
`timescale 1ns / 1ps
// shared types, register indexes and datapath op codes for the frame rms attention score block
// no dependencies

package frms_pkg;

  localparam int unsigned FRAME_SAMPLES_DEF = 256;
  localparam int unsigned WINDOW_FRAMES_DEF = 7;

  localparam int unsigned ROOT_BITS = 20;
  localparam int unsigned DIV_BITS  = 44;

  localparam logic [2:0] CFG_FOCUS  = 3'd0;
  localparam logic [2:0] CFG_RELAX  = 3'd1;
  localparam logic [2:0] CFG_DFULL  = 3'd2;
  localparam logic [2:0] CFG_SPIKE  = 3'd3;
  localparam logic [2:0] CFG_ALPHA  = 3'd4;
  localparam logic [2:0] CFG_SPARE  = 3'd7;

  typedef struct packed {
    logic [15:0] sample;
    logic        frame_end;
  } in_t;

  typedef struct packed {
    logic [6:0] attention;
    logic       rejected;
  } out_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_ROOT_LD,
    OP_ROOT_STEP,
    OP_DELTA,
    OP_PUSH,
    OP_DIVD_LD,
    OP_DIV_STEP,
    OP_DIVR_LD,
    OP_AVR_SAVE,
    OP_W_LD,
    OP_W_SAVE,
    OP_P_LD,
    OP_P_SAVE,
    OP_MUL1,
    OP_MUL2,
    OP_RAW,
    OP_MUL3,
    OP_MUL4,
    OP_FINISH
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   in_fire;
  } dp_cmd_t;

  typedef struct packed {
    logic spike;
    logic w_div;
    logic p_div;
  } dp_stat_t;

endpackage

FILE: hdl/frms_dp.sv
`timescale 1ns / 1ps
// datapath: square accumulator, bit-serial square root, ring sums, serial divider, multiplier
// depends on frms_pkg; driven by frms_ctrl

module frms_dp import frms_pkg::*; #(
  parameter int unsigned FRAME_SAMPLES = FRAME_SAMPLES_DEF,
  parameter int unsigned WINDOW_FRAMES = WINDOW_FRAMES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  output dp_stat_t    stat_o,
  input  in_t         in_data_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output out_t        out_data_o
);

  localparam int unsigned LOG2 = $clog2(FRAME_SAMPLES);
  localparam int unsigned SUMW = 32 + LOG2;
  localparam logic [SUMW-1:0] CAP = SUMW'(64'hFFFE0001) << LOG2;
  localparam int unsigned PW  = (WINDOW_FRAMES > 1) ? $clog2(WINDOW_FRAMES) : 1;
  localparam int unsigned FW  = $clog2(WINDOW_FRAMES + 1);
  localparam int unsigned SSW = 20 + FW;
  localparam int unsigned SSX = SSW + 1;

  logic [15:0] focus_q, relax_q, dfull_q, spike_lim_q, alpha_q;

  logic [31:0]     sq_q;
  logic            sq_vld_q;
  logic [SUMW-1:0] sum_q;

  logic [39:0] rad_q;
  logic [20:0] srem_q;
  logic [19:0] root_q;
  logic [22:0] srem_sh, strial, sdiff;
  logic        sge;

  logic [19:0] prev_q, delta_q, delta_c, adiff;
  logic        spike_q;

  logic [19:0]    rms_ring_q [WINDOW_FRAMES];
  logic [19:0]    dlt_ring_q [WINDOW_FRAMES];
  logic [PW-1:0]  ptr_q;
  logic [FW-1:0]  fill_q;
  logic [SSW-1:0] sum_r_q, sum_d_q;
  logic           full;
  logic [19:0]    old_r, old_d;

  logic [DIV_BITS-1:0] dvd_q;
  logic [19:0]         drem_q, dvs_q;
  logic [20:0]         dsh;
  logic                dge;

  logic [19:0] avg_d_q, avg_r_q, f_thr, r_thr, d_thr;
  logic [16:0] w_q, wd;
  logic [22:0] dp_q, raw_q, sm_q, sm_new;
  logic [6:0]  held_q;
  logic [23:0] rp;
  logic [26:0] ad, ad100;
  logic [23:0] ma;
  logic [16:0] mb;
  logic [40:0] prod;
  logic [41:0] acc_q;
  logic        w_lo, w_hi, p_full;
  out_t        out_q;

  assign f_thr = {focus_q, 4'd0};
  assign r_thr = {relax_q, 4'd0};
  assign d_thr = {dfull_q, 4'd0};

  assign srem_sh = {srem_q, rad_q[39:38]};
  assign strial  = {1'b0, root_q, 2'b01};
  assign sge     = srem_sh >= strial;
  assign sdiff   = srem_sh - strial;

  assign adiff   = (root_q > prev_q) ? root_q - prev_q : prev_q - root_q;
  assign delta_c = (prev_q == 20'd0) ? 20'd0 : adiff;

  assign full  = fill_q == FW'(WINDOW_FRAMES);
  assign old_r = full ? rms_ring_q[ptr_q] : 20'd0;
  assign old_d = full ? dlt_ring_q[ptr_q] : 20'd0;

  assign dsh = {drem_q, dvd_q[DIV_BITS-1]};
  assign dge = dsh >= {1'b0, dvs_q};

  assign w_lo   = avg_r_q <= f_thr;
  assign w_hi   = avg_r_q >= r_thr;
  assign p_full = avg_d_q >= d_thr;

  assign rp    = ({7'd0, w_q} << 6) + ({7'd0, w_q} << 5) + ({7'd0, w_q} << 2);
  assign wd    = 17'h10000 - {1'b0, w_q[16:1]};
  assign ad    = {7'd0, avg_d_q};
  assign ad100 = (ad << 6) + (ad << 5) + (ad << 2);

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd_i.op)
      OP_MUL1: begin
        ma = rp;
        mb = w_q;
      end
      OP_MUL2: begin
        ma = {1'b0, dp_q};
        mb = wd;
      end
      OP_MUL3: begin
        ma = {1'b0, sm_q};
        mb = 17'h10000 - {1'b0, alpha_q};
      end
      OP_MUL4: begin
        ma = {1'b0, raw_q};
        mb = {1'b0, alpha_q};
      end
      default: ;
    endcase
  end

  assign prod   = {17'd0, ma} * {24'd0, mb};
  assign sm_new = acc_q[38:16];

  assign stat_o = '{spike: spike_q, w_div: !w_lo && !w_hi, p_div: !p_full};
  assign out_data_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focus_q     <= 16'd800;
      relax_q     <= 16'd1100;
      dfull_q     <= 16'd80;
      spike_lim_q <= 16'd500;
      alpha_q     <= 16'd19661;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FOCUS: focus_q     <= cfg_data_i;
        CFG_RELAX: relax_q     <= cfg_data_i;
        CFG_DFULL: dfull_q     <= cfg_data_i;
        CFG_SPIKE: spike_lim_q <= cfg_data_i;
        CFG_ALPHA: alpha_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q <= 1'b0;
      sum_q    <= '0;
      prev_q   <= '0;
      spike_q  <= 1'b0;
      ptr_q    <= '0;
      fill_q   <= '0;
      sum_r_q  <= '0;
      sum_d_q  <= '0;
      sm_q     <= 23'(50) << 16;
      held_q   <= 7'd50;
    end else begin
      sq_vld_q <= cmd_i.in_fire;
      if (cmd_i.op == OP_ROOT_LD) begin
        sum_q <= '0;
      end else if (sq_vld_q) begin
        sum_q <= (sum_q > CAP - SUMW'(sq_q)) ? CAP : sum_q + SUMW'(sq_q);
      end
      if (cmd_i.op == OP_DELTA) begin
        prev_q  <= root_q;
        spike_q <= delta_c > {spike_lim_q, 4'd0};
      end
      if (cmd_i.op == OP_PUSH) begin
        sum_r_q <= SSW'(SSX'(sum_r_q) + SSX'(root_q) - SSX'(old_r));
        sum_d_q <= SSW'(SSX'(sum_d_q) + SSX'(delta_q) - SSX'(old_d));
        ptr_q   <= (ptr_q == PW'(WINDOW_FRAMES - 1)) ? '0 : ptr_q + 1'b1;
        if (!full) begin
          fill_q <= fill_q + 1'b1;
        end
      end
      if (cmd_i.op == OP_FINISH && !spike_q) begin
        sm_q   <= sm_new;
        held_q <= sm_new[22:16];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_fire) begin
      sq_q <= {16'd0, in_data_i.sample} * {16'd0, in_data_i.sample};
    end
    if (cmd_i.op == OP_PUSH) begin
      rms_ring_q[ptr_q] <= root_q;
      dlt_ring_q[ptr_q] <= delta_q;
    end
    case (cmd_i.op)
      OP_ROOT_LD: begin
        rad_q  <= {sum_q[SUMW-1:LOG2], 8'd0};
        srem_q <= '0;
        root_q <= '0;
      end
      OP_ROOT_STEP: begin
        rad_q  <= {rad_q[37:0], 2'b00};
        srem_q <= sge ? sdiff[20:0] : srem_sh[20:0];
        root_q <= {root_q[18:0], sge};
      end
      OP_DELTA: delta_q <= delta_c;
      OP_DIVD_LD: begin
        dvd_q  <= DIV_BITS'(sum_d_q);
        drem_q <= '0;
        dvs_q  <= 20'(fill_q);
      end
      OP_DIV_STEP: begin
        drem_q <= dge ? 20'(dsh - {1'b0, dvs_q}) : dsh[19:0];
        dvd_q  <= {dvd_q[DIV_BITS-2:0], dge};
      end
      OP_DIVR_LD: begin
        avg_d_q <= dvd_q[19:0];
        dvd_q   <= DIV_BITS'(sum_r_q);
        drem_q  <= '0;
        dvs_q   <= 20'(fill_q);
      end
      OP_AVR_SAVE: avg_r_q <= dvd_q[19:0];
      OP_W_LD: begin
        w_q    <= w_lo ? 17'h10000 : 17'd0;
        dvd_q  <= {8'd0, avg_r_q - f_thr, 16'd0};
        drem_q <= '0;
        dvs_q  <= r_thr - f_thr;
      end
      OP_W_SAVE: w_q <= 17'h10000 - dvd_q[16:0];
      OP_P_LD: begin
        dp_q   <= 23'(100) << 16;
        dvd_q  <= {1'b0, ad100, 16'd0};
        drem_q <= '0;
        dvs_q  <= d_thr;
      end
      OP_P_SAVE: dp_q <= dvd_q[22:0];
      OP_MUL1: acc_q <= {1'b0, prod};
      OP_MUL2: acc_q <= acc_q + {1'b0, prod};
      OP_RAW: raw_q <= (acc_q[41:16] > (26'(100) << 16)) ? 23'(100) << 16 : acc_q[38:16];
      OP_MUL3: acc_q <= {1'b0, prod};
      OP_MUL4: acc_q <= acc_q + {1'b0, prod};
      OP_FINISH: begin
        if (spike_q) begin
          out_q <= '{attention: held_q, rejected: 1'b1};
        end else begin
          out_q <= '{attention: sm_new[22:16], rejected: 1'b0};
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: hdl/frms_ctrl.sv
`timescale 1ns / 1ps
// controller state machine: sample handshake, frame-end sequencing, result register valid
// depends on frms_pkg; drives frms_dp

module frms_ctrl import frms_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     frame_end_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output dp_cmd_t  cmd_o,
  input  dp_stat_t stat_i
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_ACC, ST_RLD, ST_RSTEP, ST_DELTA, ST_CHECK, ST_PUSH,
    ST_DLD, ST_DSTEP, ST_RVLD, ST_RVSTEP, ST_AVR, ST_WLD, ST_WSTEP, ST_WSAVE,
    ST_PLD, ST_PSTEP, ST_PSAVE, ST_MUL1, ST_MUL2, ST_RAW, ST_MUL3, ST_MUL4, ST_FIN
  } state_e;

  state_e     state_q;
  logic [5:0] cnt_q;
  logic       out_valid_q;
  logic       free;

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign free        = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o.in_fire = in_valid_i && in_ready_o;
    unique case (state_q)
      ST_RLD:                        cmd_o.op = OP_ROOT_LD;
      ST_RSTEP:                      cmd_o.op = OP_ROOT_STEP;
      ST_DELTA:                      cmd_o.op = OP_DELTA;
      ST_PUSH:                       cmd_o.op = OP_PUSH;
      ST_DLD:                        cmd_o.op = OP_DIVD_LD;
      ST_DSTEP, ST_RVSTEP, ST_WSTEP,
      ST_PSTEP:                      cmd_o.op = OP_DIV_STEP;
      ST_RVLD:                       cmd_o.op = OP_DIVR_LD;
      ST_AVR:                        cmd_o.op = OP_AVR_SAVE;
      ST_WLD:                        cmd_o.op = OP_W_LD;
      ST_WSAVE:                      cmd_o.op = OP_W_SAVE;
      ST_PLD:                        cmd_o.op = OP_P_LD;
      ST_PSAVE:                      cmd_o.op = OP_P_SAVE;
      ST_MUL1:                       cmd_o.op = OP_MUL1;
      ST_MUL2:                       cmd_o.op = OP_MUL2;
      ST_RAW:                        cmd_o.op = OP_RAW;
      ST_MUL3:                       cmd_o.op = OP_MUL3;
      ST_MUL4:                       cmd_o.op = OP_MUL4;
      ST_FIN:                        cmd_o.op = free ? OP_FINISH : OP_NONE;
      default:                       cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i && frame_end_i) begin
            state_q <= ST_ACC;
          end
        end
        ST_ACC: state_q <= ST_RLD;
        ST_RLD: begin
          cnt_q   <= 6'(ROOT_BITS - 1);
          state_q <= ST_RSTEP;
        end
        ST_RSTEP: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == 6'd0) begin
            state_q <= ST_DELTA;
          end
        end
        ST_DELTA: state_q <= ST_CHECK;
        ST_CHECK: state_q <= stat_i.spike ? ST_FIN : ST_PUSH;
        ST_PUSH:  state_q <= ST_DLD;
        ST_DLD: begin
          cnt_q   <= 6'(DIV_BITS - 1);
          state_q <= ST_DSTEP;
        end
        ST_DSTEP: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == 6'd0) begin
            state_q <= ST_RVLD;
          end
        end
        ST_RVLD: begin
          cnt_q   <= 6'(DIV_BITS - 1);
          state_q <= ST_RVSTEP;
        end
        ST_RVSTEP: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == 6'd0) begin
            state_q <= ST_AVR;
          end
        end
        ST_AVR: state_q <= ST_WLD;
        ST_WLD: begin
          cnt_q   <= 6'(DIV_BITS - 1);
          state_q <= stat_i.w_div ? ST_WSTEP : ST_PLD;
        end
        ST_WSTEP: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == 6'd0) begin
            state_q <= ST_WSAVE;
          end
        end
        ST_WSAVE: state_q <= ST_PLD;
        ST_PLD: begin
          cnt_q   <= 6'(DIV_BITS - 1);
          state_q <= stat_i.p_div ? ST_PSTEP : ST_MUL1;
        end
        ST_PSTEP: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == 6'd0) begin
            state_q <= ST_PSAVE;
          end
        end
        ST_PSAVE: state_q <= ST_MUL1;
        ST_MUL1:  state_q <= ST_MUL2;
        ST_MUL2:  state_q <= ST_RAW;
        ST_RAW:   state_q <= ST_MUL3;
        ST_MUL3:  state_q <= ST_MUL4;
        ST_MUL4:  state_q <= ST_FIN;
        ST_FIN: begin
          if (free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_fe_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && frame_end_i |=> !in_ready_o)
    else $error("input still ready after frame end");
  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_FIN))
    else $error("result without finish");
  a_spike_skips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CHECK && stat_i.spike |=> state_q == ST_FIN)
    else $error("rejected frame entered ring update");
`endif

endmodule

FILE: hdl/frame_rms_attention_score_top.sv
`timescale 1ns / 1ps
// Frame RMS attention score. Samples are taken one per cycle while a frame accumulates. The
// sample marked frame_end starts the frame-end sequence and holds in_ready_o low until the
// result is written to the output register. The weight and delta divisions run only when the
// averages fall inside their ranges, and a frame rejected as a spike skips the ring update and
// every division. The 20-step square root and the 44-step serial divider, used for both ring
// averages and both score ratios, are the longest steps of that sequence. Config writes are
// always accepted and must happen only while the block is idle.
// depends on frms_pkg, frms_ctrl, frms_dp

module frame_rms_attention_score_top import frms_pkg::*; #(
  parameter int unsigned FRAME_SAMPLES = FRAME_SAMPLES_DEF,
  parameter int unsigned WINDOW_FRAMES = WINDOW_FRAMES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  frms_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .frame_end_i (in_data_i.frame_end),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  frms_dp #(
    .FRAME_SAMPLES (FRAME_SAMPLES),
    .WINDOW_FRAMES (WINDOW_FRAMES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_data_o  (out_data_o)
  );

endmodule
